// ===== design/trxc_pkg.sv =====
package trxc_pkg;

  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W   = 32;

  localparam logic [7:0] CH_MASK7 = 8'h7f;
  localparam logic [6:0] CH_XON   = 7'h11;
  localparam logic [6:0] CH_XOFF  = 7'h13;
  localparam logic [7:0] CH_MARK  = 8'hff;

  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_SUSPEND = 2'd1,
    KIND_RESUME  = 2'd2,
    KIND_BREAK   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OPEN       = 3'd0,
    REG_FLOW       = 3'd1,
    REG_ANY_RESTART = 3'd2,
    REG_PARITY     = 3'd3,
    REG_IGN_BREAK  = 3'd4,
    REG_BREAK_SIG  = 3'd5,
    REG_IGN_ERROR  = 3'd6,
    REG_MARK_STRIP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] open_line;
    logic [15:0] flow_enable;
    logic [15:0] any_restart;
    logic [15:0] parity_check;
    logic [15:0] ignore_break;
    logic [15:0] break_signal;
    logic [15:0] ignore_error;
    logic [15:0] mark;
    logic [15:0] strip;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_t;

  typedef struct packed {
    logic [3:0]      line;
    logic [1:0]      last_idx;
    res_t [3:0]      res;
  } entry_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] data);
    res_t r;
    r.kind = kind;
    r.data = data;
    return r;
  endfunction

endpackage

// ===== design/trxc_front.sv =====
module trxc_front import trxc_pkg::*; #(
  parameter int LINES = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [3:0] in_line,
  input  logic [7:0] in_data_byte,
  input  logic       in_parity_error,
  input  logic       in_framing_error,
  input  logic       in_overrun_error,
  input  logic       q_full,
  output logic       q_push,
  output entry_t     q_entry
);

  localparam int LIDX_W = (LINES > 1) ? $clog2(LINES) : 1;

  logic [LINES-1:0]  stopped_r;
  logic [LIDX_W-1:0] idx;
  logic              in_range;
  logic              open_hit;
  logic              stopped_cur;
  logic              stopped_nxt;
  logic              accept;
  logic [6:0]        ch;
  logic              pe;
  logic              err;
  logic              done;
  logic              drop;
  logic              brk;
  logic [2:0]        n;
  entry_t            ent;

  assign idx      = in_line[LIDX_W-1:0];
  assign in_range = (int'(in_line) < LINES);
  assign open_hit = in_range && cfg.open_line[in_line];
  assign stopped_cur = in_range ? stopped_r[idx] : 1'b0;
  assign ch       = in_data_byte[6:0];
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    ent         = '0;
    ent.line    = in_line;
    n           = 3'd0;
    done        = 1'b0;
    drop        = 1'b0;
    brk         = 1'b0;
    stopped_nxt = stopped_cur;
    pe  = in_parity_error && cfg.parity_check[in_line];
    err = pe || in_framing_error || in_overrun_error;

    if (cfg.flow_enable[in_line]) begin
      if (stopped_cur) begin
        if (ch == CH_XON || cfg.any_restart[in_line]) begin
          stopped_nxt = 1'b0;
          ent.res[n[1:0]] = mk_res(KIND_RESUME, 8'h00);
          n = n + 3'd1;
        end
      end else if (ch == CH_XOFF) begin
        stopped_nxt = 1'b1;
        ent.res[n[1:0]] = mk_res(KIND_SUSPEND, 8'h00);
        n = n + 3'd1;
      end
      if (ch == CH_XON || ch == CH_XOFF) begin
        done = 1'b1;
      end
    end

    if (!done) begin
      if (err) begin
        if (in_data_byte == 8'h00) begin
          if (cfg.ignore_break[in_line]) begin
            drop = 1'b1;
          end else if (cfg.break_signal[in_line]) begin
            brk = 1'b1;
          end
        end else if (cfg.ignore_error[in_line]) begin
          drop = 1'b1;
        end
        if (brk) begin
          ent.res[n[1:0]] = mk_res(KIND_BREAK, 8'h00);
          n = n + 3'd1;
        end else if (!drop) begin
          if (cfg.mark[in_line]) begin
            ent.res[n[1:0]] = mk_res(KIND_BYTE, CH_MARK);
            n = n + 3'd1;
            ent.res[n[1:0]] = mk_res(KIND_BYTE, 8'h00);
            n = n + 3'd1;
            ent.res[n[1:0]] = mk_res(KIND_BYTE, in_data_byte);
            n = n + 3'd1;
          end else begin
            ent.res[n[1:0]] = mk_res(KIND_BYTE, 8'h00);
            n = n + 3'd1;
          end
        end
      end else if (cfg.strip[in_line]) begin
        ent.res[n[1:0]] = mk_res(KIND_BYTE, in_data_byte & CH_MASK7);
        n = n + 3'd1;
      end else begin
        if (in_data_byte == CH_MARK && cfg.mark[in_line]) begin
          ent.res[n[1:0]] = mk_res(KIND_BYTE, CH_MARK);
          n = n + 3'd1;
        end
        ent.res[n[1:0]] = mk_res(KIND_BYTE, in_data_byte);
        n = n + 3'd1;
      end
    end

    ent.last_idx = 2'(n - 3'd1);
  end

  assign q_push  = accept && open_hit && (n != 3'd0);
  assign q_entry = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stopped_r <= '0;
    end else if (accept && open_hit) begin
      stopped_r[idx] <= stopped_nxt;
    end
  end

endmodule

// ===== design/trxc_queue.sv =====
module trxc_queue import trxc_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head_entry
);

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic              do_push;
  logic              do_pop;

  assign full       = (count_r == QCNT_W'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_entry = mem[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
    end
  end

endmodule

// ===== design/trxc_back.sv =====
module trxc_back import trxc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  entry_t     head_entry,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_line,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       out_valid_r;
  logic [3:0] out_line_r;
  logic [1:0] out_kind_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;
  logic [1:0] idx_r;
  logic       load;
  logic       is_last;
  res_t       cur;

  assign cur     = head_entry.res[idx_r];
  assign is_last = (idx_r == head_entry.last_idx);
  assign load    = head_valid && (!out_valid_r || !out_stall);
  assign pop     = load && is_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        idx_r       <= is_last ? 2'd0 : idx_r + 2'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_line_r <= head_entry.line;
      out_kind_r <= cur.kind;
      out_byte_r <= cur.data;
      out_last_r <= is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_line  = out_line_r;
  assign out_kind  = out_kind_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

// ===== design/termio_rx_char_conditioner_top.sv =====
// Receive character conditioner for up to 16 serial lines. Each input word
// (line, data byte, parity, framing and overrun flags) is classified
// combinationally by the front end, which applies XON/XOFF flow control
// and the termio error rules and queues the zero to four resulting output
// words. The back end drains the queue at one output word per cycle while
// out_stall is low, through a registered output; input words are taken
// every cycle while the two-entry queue has room. Words for lines that are
// not open, and words that produce no result, are absorbed without reaching
// the queue. Configuration is written through cfg_we, cfg_index and
// cfg_wdata while the block is idle.
module termio_rx_char_conditioner_top import trxc_pkg::*; #(
  parameter int LINES = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [3:0]           in_line,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_parity_error,
  input  logic                 in_framing_error,
  input  logic                 in_overrun_error,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [3:0]           out_line,
  output logic [1:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last
);

  cfg_t   cfg_r;
  logic   q_full;
  logic   q_push;
  entry_t q_entry;
  logic   q_pop;
  logic   head_valid;
  entry_t head_entry;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_OPEN:        cfg_r.open_line    <= cfg_wdata[15:0];
        REG_FLOW:        cfg_r.flow_enable  <= cfg_wdata[15:0];
        REG_ANY_RESTART: cfg_r.any_restart  <= cfg_wdata[15:0];
        REG_PARITY:      cfg_r.parity_check <= cfg_wdata[15:0];
        REG_IGN_BREAK:   cfg_r.ignore_break <= cfg_wdata[15:0];
        REG_BREAK_SIG:   cfg_r.break_signal <= cfg_wdata[15:0];
        REG_IGN_ERROR:   cfg_r.ignore_error <= cfg_wdata[15:0];
        REG_MARK_STRIP: begin
          cfg_r.mark  <= cfg_wdata[15:0];
          cfg_r.strip <= cfg_wdata[31:16];
        end
        default: begin
        end
      endcase
    end
  end

  trxc_front #(
    .LINES(LINES)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_line          (in_line),
    .in_data_byte     (in_data_byte),
    .in_parity_error  (in_parity_error),
    .in_framing_error (in_framing_error),
    .in_overrun_error (in_overrun_error),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_entry          (q_entry)
  );

  trxc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  trxc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_line   (out_line),
    .out_kind   (out_kind),
    .out_byte   (out_byte),
    .out_last   (out_last)
  );

endmodule
